/* design/lfsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_pkg: shared types and constants of the lowest free slot allocator
// Slot geometry, request and status codes, cell link and command structs,
// and the priority encoders that the cells use on their local slot bits.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  // Pool geometry. The pool is cut into cells of CELL_SLOTS slots each.
  localparam int SLOT_COUNT = 64;
  localparam int CELL_SLOTS = 8;
  localparam int CELL_COUNT = SLOT_COUNT / CELL_SLOTS;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CELL_W     = $clog2(CELL_SLOTS);
  localparam int GRP_W      = SLOT_W - CELL_W;
  localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int TOP_W      = SLOT_W + 1;

  // Request codes of an input item.
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_e_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic              clr_all;
    logic [SLOT_W-1:0] addr;
  } cmd_t;

  // Search result handed from one cell to its neighbor.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } scan_t;

  // Position of the lowest set bit; zero when no bit is set.
  function automatic logic [CELL_W-1:0] low_one(input logic [CELL_SLOTS-1:0] bits);
    logic [CELL_W-1:0] pos;
    pos = '0;
    for (int i = CELL_SLOTS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        pos = CELL_W'(i);
      end
    end
    return pos;
  endfunction

  // Position of the highest set bit; zero when no bit is set.
  function automatic logic [CELL_W-1:0] high_one(input logic [CELL_SLOTS-1:0] bits);
    logic [CELL_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < CELL_SLOTS; i++) begin
      if (bits[i]) begin
        pos = CELL_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* design/lowest_free_slot_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_core: lowest free slot allocator, top level
// Bitmap allocator over a fixed pool of slots held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid, in_ready, in_req_type, in_slot_in) takes one
//   request item: allocate the lowest free slot, free a slot, clear all, or
//   no operation. Every item gives exactly one result item.
// - The result channel (out_valid, out_ready, out_*) reports the granted or
//   freed slot, a status, the live count, a full flag, the highest live slot
//   (-1 when none) and the lowest free slot (last slot when the pool is full).
// - For an item, the cells update their live bits at the accept edge, then in
//   the scan state the free and live searches ripple through the cell chain
//   and load the output register. No new item is taken in the scan state, so
//   each item is loaded into the output register before the next is accepted.
// - out_valid rises when the scan state loads the output register once it is free.
// - The output register parts the two sides: the next item is accepted while
//   a result waits. If the receiver stalls, the search cycle holds until the
//   output register frees, and in_ready stays low meanwhile.
// - Reset marks every slot free and empties the output register at once.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_core
  import lfsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_req_type,
  input  logic [SLOT_W-1:0]       in_slot_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SLOT_W-1:0]       out_slot_out,
  output logic [1:0]              out_status,
  output logic [COUNT_W-1:0]      out_live_total,
  output logic                    out_pool_full,
  output logic signed [TOP_W-1:0] out_top_live,
  output logic [SLOT_W-1:0]       out_first_free
);

  state_e_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]        lf_r, lf_nxt;
  logic [COUNT_W-1:0]       cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]        res_slot_r, res_slot_nxt;
  status_e_t                res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]        out_slot_r;
  logic [1:0]               out_status_r;
  logic [COUNT_W-1:0]       out_cnt_r;
  logic                     out_full_r;
  logic signed [TOP_W-1:0]  out_top_r, top_nxt;
  logic [SLOT_W-1:0]        out_ff_r;

  logic                     accept;
  logic                     load;
  logic                     full;
  logic                     in_range;
  logic                     hit;
  req_e_t                   req;
  cmd_t                     cmd;
  scan_t                    free_res;
  scan_t                    live_res;

  assign req      = req_e_t'(in_req_type);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign full     = (cnt_r == COUNT_W'(SLOT_COUNT));
  assign in_range = ({1'b0, in_slot_in} < (SLOT_W + 1)'(SLOT_COUNT));
  assign load     = (state_r == S_SCAN) && (!out_valid_r || out_ready);

  // Command to the cells: allocate writes the tracked lowest free slot.
  always_comb begin
    cmd.addr    = (req == REQ_ALLOC) ? lf_r : in_slot_in;
    cmd.set_en  = accept && (req == REQ_ALLOC) && !full;
    cmd.clr_en  = accept && (req == REQ_FREE) && in_range && hit;
    cmd.clr_all = accept && (req == REQ_CLEAR);
  end

  lfsa_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .first_free (free_res),
    .top_live   (live_res),
    .hit        (hit)
  );

  // Request decode: live count, granted slot and status of this item.
  always_comb begin
    cnt_nxt        = cnt_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    if (accept) begin
      res_slot_nxt   = '0;
      res_status_nxt = ST_DONE;
      unique case (req)
        REQ_ALLOC: begin
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            res_slot_nxt = lf_r;
            cnt_nxt      = cnt_r + COUNT_W'(1);
          end
        end
        REQ_FREE: begin
          res_slot_nxt = in_slot_in;
          if (cmd.clr_en) begin
            cnt_nxt = cnt_r - COUNT_W'(1);
          end else begin
            res_status_nxt = ST_NOT_LIVE;
          end
        end
        REQ_CLEAR: begin
          cnt_nxt = '0;
        end
        REQ_NOP: begin
          cnt_nxt = cnt_r;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // Search results of the updated live map.
  always_comb begin
    lf_nxt  = free_res.found ? free_res.idx : SLOT_W'(SLOT_COUNT - 1);
    top_nxt = live_res.found ? $signed({1'b0, live_res.idx}) : '1;
  end

  // Controller: accept in idle, search and load the output in scan.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      lf_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (load) begin
        lf_r <= lf_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    if (load) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= cnt_r;
      out_full_r   <= full;
      out_top_r    <= top_nxt;
      out_ff_r     <= lf_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_out   = out_slot_r;
  assign out_status     = out_status_r;
  assign out_live_total = out_cnt_r;
  assign out_pool_full  = out_full_r;
  assign out_top_live   = out_top_r;
  assign out_first_free = out_ff_r;

endmodule

/* design/lfsa_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_cell: one cell of the slot chain
// Holds the live bits of a group of slots, applies the broadcast command and
// passes the lowest free and highest live search results to its neighbors.
// ----------------------------------------------------------------------------
module lfsa_cell
  import lfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [GRP_W-1:0] cell_id,
  input  cmd_t             cmd,
  input  scan_t            free_in,
  output scan_t            free_out,
  input  scan_t            live_in,
  output scan_t            live_out,
  output logic             hit
);

  logic [CELL_SLOTS-1:0] live_r;
  logic [CELL_SLOTS-1:0] live_nxt;
  logic                  sel;
  logic [CELL_W-1:0]     lo_addr;

  assign sel     = (cmd.addr[SLOT_W-1:CELL_W] == cell_id);
  assign lo_addr = cmd.addr[CELL_W-1:0];

  // The addressed live bit, seen by the controller for free requests.
  assign hit = sel & live_r[lo_addr];

  // Apply the command: clear all wins, then set, then clear one slot.
  always_comb begin
    live_nxt = live_r;
    if (cmd.clr_all) begin
      live_nxt = '0;
    end else if (cmd.set_en && sel) begin
      live_nxt[lo_addr] = 1'b1;
    end else if (cmd.clr_en && sel) begin
      live_nxt[lo_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else begin
      live_r <= live_nxt;
    end
  end

  // Lowest free search runs upward: a lower cell's find takes precedence.
  always_comb begin
    if (free_in.found) begin
      free_out = free_in;
    end else begin
      free_out.found = |(~live_r);
      free_out.idx   = {cell_id, low_one(~live_r)};
    end
  end

  // Highest live search runs downward: an upper cell's find takes precedence.
  always_comb begin
    if (live_in.found) begin
      live_out = live_in;
    end else begin
      live_out.found = |live_r;
      live_out.idx   = {cell_id, high_one(live_r)};
    end
  end

endmodule

/* design/lfsa_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_chain: row of slot cells
// Links the cells so that the free search travels upward and the live search
// travels downward, and gathers the addressed live bit.
// ----------------------------------------------------------------------------
module lfsa_chain
  import lfsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  output scan_t first_free,
  output scan_t top_live,
  output logic  hit
);

  scan_t                 free_link [CELL_COUNT+1];
  scan_t                 live_link [CELL_COUNT+1];
  logic [CELL_COUNT-1:0] hit_vec;

  // Chain ends carry no find.
  assign free_link[0]          = '0;
  assign live_link[CELL_COUNT] = '0;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    lfsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (GRP_W'(k)),
      .cmd      (cmd),
      .free_in  (free_link[k]),
      .free_out (free_link[k+1]),
      .live_in  (live_link[k+1]),
      .live_out (live_link[k]),
      .hit      (hit_vec[k])
    );
  end

  assign first_free = free_link[CELL_COUNT];
  assign top_live   = live_link[0];
  assign hit        = |hit_vec;

endmodule

/* design/lfsa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_checker: port level checks of the slot allocator
// Watches the top level ports and flags results that contradict each other.
// ----------------------------------------------------------------------------
module lfsa_checker
  import lfsa_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SLOT_W-1:0]       out_slot_out,
  input logic [COUNT_W-1:0]      out_live_total,
  input logic                    out_pool_full,
  input logic signed [TOP_W-1:0] out_top_live,
  input logic [SLOT_W-1:0]       out_first_free
);

  // An accepted item keeps the input closed for its search cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("lfsa: item accepted on consecutive cycles");

  // The full flag agrees with the live count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pool_full == (out_live_total == COUNT_W'(SLOT_COUNT))))
    else $error("lfsa: full flag disagrees with live count");

  // A full pool reports the last slot as lowest free, an empty one no live slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pool_full) |-> (out_first_free == SLOT_W'(SLOT_COUNT - 1)))
    else $error("lfsa: full pool with wrong lowest free slot");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_live_total == '0)) |-> (out_top_live == -1))
    else $error("lfsa: empty pool with a live slot reported");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_slot_out)))
    else $error("lfsa: stalled result item changed");

endmodule

bind lowest_free_slot_allocator_core lfsa_checker u_lfsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_slot_out   (out_slot_out),
  .out_live_total (out_live_total),
  .out_pool_full  (out_pool_full),
  .out_top_live   (out_top_live),
  .out_first_free (out_first_free)
);
